[design/mdtag_pkg.sv]
package mdtag_pkg;

  // input action codes
  localparam logic [2:0] ACT_MATCH     = 3'd0;
  localparam logic [2:0] ACT_MISMATCH  = 3'd1;
  localparam logic [2:0] ACT_DEL_START = 3'd2;
  localparam logic [2:0] ACT_DEL_CONT  = 3'd3;

  localparam int COUNT_BITS_DEFAULT = 20;

  // match run never exceeds seven decimal digits
  localparam int          DEC_DIGITS  = 7;
  localparam int          BCD_W       = 4 * DEC_DIGITS;
  localparam int          NDIG_W      = 3;
  localparam logic [31:0] DEC_CEILING = 32'd9999999;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_CARET = 8'h5e;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one burst of characters, as decided by the front part
  typedef struct packed {
    logic              has_a;
    logic [BCD_W-1:0]  bcd_a;
    logic [NDIG_W-1:0] nd_a;
    logic              has_caret;
    logic              has_base;
    logic [7:0]        base;
    logic              has_b;
    logic [BCD_W-1:0]  bcd_b;
    logic [NDIG_W-1:0] nd_b;
  } cmd_t;

  // decimal increment of a packed bcd value
  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic             carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (carry) begin
        if (v[i*4 +: 4] == 4'd9) begin
          r[i*4 +: 4] = 4'd0;
        end else begin
          r[i*4 +: 4] = v[i*4 +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // number of significant digits, at least one
  function automatic logic [NDIG_W-1:0] bcd_ndig(input logic [BCD_W-1:0] v);
    logic [NDIG_W-1:0] n;
    n = NDIG_W'(1);
    for (int i = 1; i < DEC_DIGITS; i++) begin
      if (v[i*4 +: 4] != 4'd0) n = NDIG_W'(i + 1);
    end
    return n;
  endfunction

endpackage

[design/mdtag_front.sv]
module mdtag_front #(
  parameter int COUNT_BITS = mdtag_pkg::COUNT_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       action,
  input  logic [7:0]       ref_base,
  input  logic             first_op,
  input  logic             end_of_read,
  output logic             push,
  output mdtag_pkg::cmd_t  cmd,
  input  logic             q_full
);
  import mdtag_pkg::*;

  localparam logic [63:0] FULL_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] RUN_CEIL = (FULL_MAX > 64'(DEC_CEILING)) ? 64'(DEC_CEILING)
                                                                   : FULL_MAX;

  logic [COUNT_BITS-1:0] run_bin;
  logic [BCD_W-1:0]      run_bcd;
  logic                  last_digit;

  logic                  is_match, is_mis, is_dstart, is_dcont;
  logic                  flush_a, flush_b, has_base, emit, accept;
  logic [COUNT_BITS-1:0] run_bin_after;
  logic [BCD_W-1:0]      run_bcd_after;
  logic                  last_after, base_digit;

  always_comb begin
    is_match   = (action == ACT_MATCH);
    is_mis     = (action == ACT_MISMATCH);
    is_dstart  = (action == ACT_DEL_START);
    is_dcont   = (action == ACT_DEL_CONT);
    flush_a    = is_mis || (is_dstart && !first_op);
    has_base   = is_mis || is_dstart || is_dcont;
    base_digit = (ref_base >= CHAR_ZERO) && (ref_base <= CHAR_NINE);

    run_bin_after = run_bin;
    run_bcd_after = run_bcd;
    if (is_match) begin
      if (run_bin < RUN_CEIL[COUNT_BITS-1:0]) begin
        run_bin_after = run_bin + COUNT_BITS'(1);
        run_bcd_after = bcd_inc(run_bcd);
      end
    end else if (flush_a) begin
      run_bin_after = '0;
      run_bcd_after = '0;
    end

    last_after = has_base ? base_digit : last_digit;
    flush_b    = end_of_read && ((run_bin_after != '0) || !last_after);
    emit       = flush_a || has_base || flush_b;

    cmd.has_a     = flush_a;
    cmd.bcd_a     = run_bcd;
    cmd.nd_a      = bcd_ndig(run_bcd);
    cmd.has_caret = is_dstart;
    cmd.has_base  = has_base;
    cmd.base      = ref_base;
    cmd.has_b     = flush_b;
    cmd.bcd_b     = run_bcd_after;
    cmd.nd_b      = bcd_ndig(run_bcd_after);
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_bin    <= '0;
      run_bcd    <= '0;
      last_digit <= 1'b0;
    end else if (accept) begin
      if (end_of_read) begin
        run_bin    <= '0;
        run_bcd    <= '0;
        last_digit <= 1'b0;
      end else begin
        run_bin    <= run_bin_after;
        run_bcd    <= run_bcd_after;
        last_digit <= last_after;
      end
    end
  end

endmodule

[design/mdtag_queue.sv]
module mdtag_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mdtag_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output mdtag_pkg::cmd_t head_cmd
);
  import mdtag_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

[design/mdtag_back.sv]
module mdtag_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  mdtag_pkg::cmd_t head_cmd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_last
);
  import mdtag_pkg::*;

  typedef enum logic [1:0] {
    PH_A     = 2'd0,
    PH_CARET = 2'd1,
    PH_BASE  = 2'd2,
    PH_B     = 2'd3
  } phase_t;

  phase_t            phase;
  logic [NDIG_W-1:0] idx;

  logic              adv, fire, in_digits, more_digits, is_last;
  logic [3:0]        pres, avail, later;
  phase_t            cur;
  logic [NDIG_W-1:0] nd_cur, pos;
  logic [BCD_W-1:0]  bcd_cur;
  logic [3:0]        digit;
  logic [7:0]        ch;

  always_comb begin
    pres  = {head_cmd.has_b, head_cmd.has_base, head_cmd.has_caret, head_cmd.has_a};
    avail = pres & 4'(4'b1111 << phase);
    if (avail[0]) begin
      cur = PH_A;
    end else if (avail[1]) begin
      cur = PH_CARET;
    end else if (avail[2]) begin
      cur = PH_BASE;
    end else begin
      cur = PH_B;
    end
    later = pres & 4'(4'b1110 << cur);

    in_digits = (cur == PH_A) || (cur == PH_B);
    nd_cur    = (cur == PH_A) ? head_cmd.nd_a : head_cmd.nd_b;
    bcd_cur   = (cur == PH_A) ? head_cmd.bcd_a : head_cmd.bcd_b;
    // most significant digit first
    pos       = nd_cur - NDIG_W'(1) - idx;
    digit     = bcd_cur[pos*4 +: 4];

    more_digits = in_digits && (({1'b0, idx} + 4'd1) < {1'b0, nd_cur});
    is_last     = !more_digits && (later == 4'd0);

    case (cur)
      PH_A:     ch = CHAR_ZERO | {4'h0, digit};
      PH_CARET: ch = CHAR_CARET;
      PH_BASE:  ch = head_cmd.base;
      PH_B:     ch = CHAR_ZERO | {4'h0, digit};
      default:  ch = CHAR_ZERO;
    endcase
  end

  assign adv  = !out_valid || out_ready;
  assign fire = adv && head_valid;
  assign pop  = fire && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_A;
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
      out_char  <= ch;
      out_last  <= is_last;
      if (more_digits) begin
        idx <= idx + NDIG_W'(1);
      end else begin
        idx   <= '0;
        phase <= is_last ? PH_A : phase_t'(cur + 2'd1);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[design/md_tag_string_generator.sv]
// md tag string generator: takes one aligned reference position per input word
// and produces the ascii characters of an md:z string, one character per output
// word, with tlast on the final character that a given input word causes.
// matches are only counted (saturating at 9999999 or the count width); a
// mismatch writes the pending count in decimal then the base, a deletion start
// writes the count (not when it is the read's first operation) then '^' and the
// base, and end of read closes with the count when needed. an input word is
// taken every cycle while the two-entry burst queue has room; the output side
// delivers one character per cycle while m_tready allows, so an input word that
// causes k characters (k at most 10) holds the output character sequencer until
// all k have gone out, and that sequencer sets the sustained rate. words that
// cause no character are taken at once unless the queue is full, so long bursts
// ahead of them can still hold them back.
module md_tag_string_generator #(
  parameter int COUNT_BITS = mdtag_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ref_base
  input  logic [3:0]  s_tuser,   // [2:0] action, [3] first_op
  input  logic        s_tlast,   // end_of_read
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] md_char
  output logic        m_tlast    // burst_last
);
  import mdtag_pkg::*;

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // front: classify the word, keep the match run in binary and bcd
  mdtag_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .action      (s_tuser[2:0]),
    .ref_base    (s_tdata),
    .first_op    (s_tuser[3]),
    .end_of_read (s_tlast),
    .push        (push),
    .cmd         (push_cmd),
    .q_full      (q_full)
  );

  // short queue of character bursts
  mdtag_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back: walk each burst one character a cycle, while the output is not stalled, into the output register
  mdtag_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

[sim/tb_md_tag_string_generator.sv]
module tb_md_tag_string_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import mdtag_pkg::*;

  // codes the block treats as skip
  localparam logic [2:0] ACT_SKIP  = 3'd4;
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  // match counter width of the instance and the count at which it saturates
  localparam int    RUN_BITS = COUNT_BITS_DEFAULT;
  localparam longint RUN_FULL = (RUN_BITS >= 32) ? 64'hFFFFFFFF
                                                 : (64'd1 << RUN_BITS) - 64'd1;
  localparam longint RUN_CEIL = (RUN_FULL > longint'(DEC_CEILING)) ?
                                longint'(DEC_CEILING) : RUN_FULL;

  // least number of non-skip words the random part sends
  localparam int RANDOM_WORDS = 160;

  // one directed row: the input word, how often it repeats, and where it is
  // obvious, the characters it must produce (first character in the high bytes)
  typedef struct packed {
    logic [2:0]  act;
    logic [7:0]  base;
    logic        first;
    logic        eor;
    logic [31:0] reps;
    logic [3:0]  n_typed;
    logic [79:0] typed;
  } dir_row_t;

  // one expected output word
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } md_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;   // [7:0] ref_base
  logic [3:0] s_tuser = '0;   // [2:0] action, [3] first_op
  logic       s_tlast = 1'b0; // end_of_read
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;        // [7:0] md_char
  logic       m_tlast;        // burst_last

  // predictor state
  logic [RUN_BITS-1:0] run_len = '0;
  logic                prev_digit = 1'b0;
  logic [7:0]          burst_q[$];

  // characters still owed by the block, oldest first
  md_word_t md_expect[$];

  int  mismatches = 0;
  int  busy_words = 0;
  int  hold_cycles = 0;
  bit  tx_gaps = 1'b1;
  bit  rx_stalls = 1'b1;
  string bases = "ACGTN";

  md_tag_string_generator #(
    .COUNT_BITS(RUN_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor of the md string
  // ---------------------------------------------------------------------------

  function automatic void put_md(input logic [7:0] c);
    burst_q.push_back(c);
    prev_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // pending match count as decimal text, a zero count gives a single zero
  function automatic void flush_run();
    string txt;
    txt = $sformatf("%0d", run_len);
    for (int i = 0; i < txt.len(); i++) put_md(txt[i]);
    run_len = '0;
  endfunction

  // characters caused by one input word, left in burst_q
  function automatic void predict_md(input logic [2:0] act, input logic [7:0] base,
                                     input logic first, input logic eor);
    burst_q.delete();
    case (act)
      ACT_MATCH: begin
        if (longint'(run_len) < RUN_CEIL) run_len = run_len + 1'b1;
      end
      ACT_MISMATCH: begin
        flush_run();
        put_md(base);
      end
      ACT_DEL_START: begin
        // a deletion that opens the read keeps its pending count
        if (!first) flush_run();
        put_md(CHAR_CARET);
        put_md(base);
      end
      ACT_DEL_CONT: begin
        put_md(base);
      end
      default: begin
      end
    endcase
    // closing flush, then a fresh read
    if (eor) begin
      if (run_len != '0 || !prev_digit) flush_run();
      run_len    = '0;
      prev_digit = 1'b0;
    end
  endfunction

  function automatic dir_row_t mk_row(input logic [2:0] act, input logic [7:0] base,
                                      input logic first, input logic eor,
                                      input int reps, input int n_typed,
                                      input logic [79:0] typed);
    dir_row_t r;
    r.act     = act;
    r.base    = base;
    r.first   = first;
    r.eor     = eor;
    r.reps    = reps;
    r.n_typed = 4'(n_typed);
    r.typed   = typed;
    return r;
  endfunction

  function automatic logic [7:0] pick_base();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
    else b = bases[$urandom_range(0, 4)];
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offers one word, waits for it to be taken and records what it must cause;
  // a typed expectation replaces the predicted characters
  task automatic send_item(input logic [2:0] act, input logic [7:0] base,
                           input logic first, input logic eor,
                           input int n_typed = 0, input logic [79:0] typed = '0);
    int       gap;
    md_word_t w;
    gap = tx_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= base;
    s_tuser  <= {first, act};
    s_tlast  <= eor;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (act <= ACT_DEL_CONT) busy_words++;
    predict_md(act, base, first, eor);
    if (n_typed > 0) begin
      burst_q.delete();
      for (int i = 0; i < n_typed; i++) burst_q.push_back(typed[(n_typed - 1 - i) * 8 +: 8]);
    end
    for (int i = 0; i < burst_q.size(); i++) begin
      w.ch   = burst_q[i];
      w.last = (i == burst_q.size() - 1);
      md_expect.push_back(w);
    end
  endtask

  task automatic wait_drained();
    while (md_expect.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls per word, plus one long hold-off
  // ---------------------------------------------------------------------------

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = rx_stalls ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      // leave the wait early when a hold-off is asked for
      while (!m_tvalid && hold_cycles == 0) @(posedge clk);
    end
  end

  // every word taken from the block is matched against the oldest expectation
  always @(posedge clk) begin
    md_word_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (md_expect.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected md char %h last %b", $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        e = md_expect.pop_front();
        if (m_tdata !== e.ch || m_tlast !== e.last) begin
          if (mismatches < 10)
            $display("%0t: md char expected %h last %b, got %h last %b",
                     $time, e.ch, e.last, m_tdata, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t dir_rows[$];
    bit       saved_gaps;
    bit       hold_done;
    int       n_reads;
    int       n_ops;
    int       pick;
    int       run;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk: plain counts, zero counts, deletions, skips, read ends
    // and extreme bases
    dir_rows.push_back(mk_row(ACT_MATCH,     "x",   1'b0, 1'b0, 3, 0, ""));
    dir_rows.push_back(mk_row(ACT_MISMATCH,  "A",   1'b0, 1'b0, 1, 2, "3A"));
    dir_rows.push_back(mk_row(ACT_MISMATCH,  "C",   1'b0, 1'b0, 1, 2, "0C"));
    dir_rows.push_back(mk_row(ACT_DEL_START, "G",   1'b0, 1'b0, 1, 3, "0^G"));
    dir_rows.push_back(mk_row(ACT_DEL_CONT,  "T",   1'b0, 1'b0, 1, 1, "T"));
    dir_rows.push_back(mk_row(ACT_MATCH,     "x",   1'b0, 1'b0, 12, 0, ""));
    dir_rows.push_back(mk_row(ACT_MATCH,     "x",   1'b0, 1'b1, 1, 2, "13"));
    // deletion opening the read, then a read end after a base
    dir_rows.push_back(mk_row(ACT_DEL_START, "A",   1'b1, 1'b0, 1, 2, "^A"));
    dir_rows.push_back(mk_row(ACT_DEL_CONT,  "C",   1'b0, 1'b1, 1, 2, "C0"));
    // opening deletion with matches pending keeps the count for later
    dir_rows.push_back(mk_row(ACT_MATCH,     "x",   1'b0, 1'b0, 2, 0, ""));
    dir_rows.push_back(mk_row(ACT_DEL_START, "T",   1'b1, 1'b0, 1, 2, "^T"));
    dir_rows.push_back(mk_row(ACT_MISMATCH,  "G",   1'b0, 1'b0, 1, 2, "2G"));
    // deletion continue with no start before it
    dir_rows.push_back(mk_row(ACT_DEL_CONT,  "A",   1'b0, 1'b0, 1, 1, "A"));
    // skip and the unused codes do nothing on their own
    dir_rows.push_back(mk_row(ACT_SKIP,      "x",   1'b0, 1'b0, 1, 0, ""));
    dir_rows.push_back(mk_row(ACT_RSVD5,     "x",   1'b1, 1'b0, 1, 0, ""));
    dir_rows.push_back(mk_row(ACT_RSVD6,     "x",   1'b0, 1'b0, 1, 0, ""));
    dir_rows.push_back(mk_row(ACT_RSVD7,     "x",   1'b0, 1'b1, 1, 1, "0"));
    // read end with nothing written yet
    dir_rows.push_back(mk_row(ACT_SKIP,      "x",   1'b0, 1'b1, 1, 1, "0"));
    dir_rows.push_back(mk_row(ACT_MATCH,     "x",   1'b0, 1'b1, 1, 1, "1"));
    dir_rows.push_back(mk_row(ACT_MISMATCH,  8'h00, 1'b1, 1'b0, 1, 0, ""));
    dir_rows.push_back(mk_row(ACT_DEL_START, 8'hff, 1'b0, 1'b1, 1, 0, ""));
    // two digit count, then a burst that opens and closes with a flush
    dir_rows.push_back(mk_row(ACT_MATCH,     "x",   1'b0, 1'b0, 10, 0, ""));
    dir_rows.push_back(mk_row(ACT_DEL_START, "T",   1'b0, 1'b1, 1, 5, "10^T0"));
    dir_rows.push_back(mk_row(ACT_MATCH,     "x",   1'b0, 1'b0, 9, 0, ""));
    dir_rows.push_back(mk_row(ACT_MISMATCH,  "N",   1'b0, 1'b1, 1, 3, "9N0"));

    foreach (dir_rows[r]) begin
      // long runs go in back to back
      saved_gaps = tx_gaps;
      if (dir_rows[r].reps > 1) tx_gaps = 1'b0;
      repeat (dir_rows[r].reps)
        send_item(dir_rows[r].act, dir_rows[r].base, dir_rows[r].first, dir_rows[r].eor,
                  int'(dir_rows[r].n_typed), dir_rows[r].typed);
      tx_gaps = saved_gaps;
    end
    s_tvalid <= 1'b0;
    wait_drained();

    // random part: mostly well-formed reads, some noise words in between
    busy_words = 0;
    hold_done  = 1'b0;
    n_reads    = 0;
    while (busy_words < RANDOM_WORDS) begin
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);

      if (!hold_done && busy_words >= 90) begin
        // output held off while mismatches keep coming, so the input backs up
        hold_cycles = 80;
        tx_gaps     = 1'b0;
        repeat (12) send_item(ACT_MISMATCH, pick_base(), 1'b0, 1'b0);
        hold_done = 1'b1;
      end

      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(3, 8))
          send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0));
      end else begin
        n_ops = $urandom_range(1, 6);
        for (int op = 0; op < n_ops; op++) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) begin
            // mostly short match runs, now and then a longer one of up to 110
            run = ($urandom_range(0, 11) == 0) ? $urandom_range(13, 110)
                                               : $urandom_range(1, 12);
            repeat (run) send_item(ACT_MATCH, pick_base(), 1'b0, 1'b0);
          end else if (pick < 8) begin
            send_item(ACT_MISMATCH, pick_base(), 1'b0, 1'b0);
          end else begin
            send_item(ACT_DEL_START, pick_base(), (op == 0), 1'b0);
            repeat ($urandom_range(0, 3)) send_item(ACT_DEL_CONT, pick_base(), 1'b0, 1'b0);
          end
        end
        send_item($urandom_range(0, 1) ? ACT_MATCH : ACT_MISMATCH, pick_base(), 1'b0, 1'b1);
      end

      // sender goes quiet until the block has delivered everything
      if (n_reads == 6 || $urandom_range(0, 9) == 0) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      n_reads++;
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && md_expect.size() == 0) begin
      $display("md_tag_string_generator test passed");
    end else begin
      $display("md_tag_string_generator test failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("md_tag_string_generator test failed");
    $finish;
  end

endmodule

[filelist.f]
design/mdtag_pkg.sv
design/mdtag_front.sv
design/mdtag_queue.sv
design/mdtag_back.sv
design/md_tag_string_generator.sv
sim/tb_md_tag_string_generator.sv
